### sv/fts_pkg.sv
// Shared types, constants and helper functions for the frame tick rate converter.
package fts_pkg;

    localparam logic [15:0] UNITS_PER_SEC   = 16'd1200;
    localparam logic [15:0] REFRESH_MIN     = 16'd31;
    localparam logic [7:0]  VSYNC_FREQ_RST  = 8'd60;
    localparam logic [7:0]  USER_FREQ_RST   = 8'd30;

    localparam int unsigned CFG_IDX_W       = 8;
    localparam logic [CFG_IDX_W-1:0] REG_VSYNC_FREQ = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_USER_FREQ  = 8'd1;

    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_RESET  = 1'b1;

    typedef enum logic [2:0] {
        DIV_STEPV,
        DIV_STEPU,
        DIV_RMAIN,
        DIV_RUSER,
        DIV_QUSER
    } div_sel_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_STEPV,
        S_STEPV_W,
        S_STEPU,
        S_STEPU_W,
        S_RMAIN,
        S_RMAIN_W,
        S_RUSER,
        S_RUSER_W,
        S_ACCUM,
        S_QUSER,
        S_QUSER_W,
        S_DONE
    } state_t;

    typedef struct packed {
        logic     accept_en;
        logic     clear;
        logic     div_start;
        div_sel_t div_sel;
        logic     accum;
        logic     zero_delta;
        logic     emit;
    } fts_cmd_t;

    typedef struct packed {
        logic in_fire;
        logic op;
        logic refresh;
        logic per_user_zero;
        logic div_done;
        logic out_free;
    } fts_sts_t;

    function automatic logic [7:0] refine(input logic [7:0] rate, input logic [15:0] q);
        logic [7:0] sum;
        sum = rate + q[7:0] + 8'd1;
        return {1'b0, sum[7:1]};
    endfunction

endpackage

### sv/fts_if.sv
// Valid/ready channel interfaces for input items, results and configuration writes.
interface fts_in_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [15:0] jiffy;

    modport source (output valid, output op, output jiffy, input ready);
    modport sink (input valid, input op, input jiffy, output ready);
endinterface

interface fts_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] main_tick;
    logic [15:0] aux_tick;
    logic [7:0]  aux_tick_step;
    logic [7:0]  main_rate_est;
    logic [7:0]  aux_rate_est;

    modport source (output valid, output main_tick, output aux_tick,
                    output aux_tick_step, output main_rate_est, output aux_rate_est,
                    input ready);
    modport sink (input valid, input main_tick, input aux_tick,
                  input aux_tick_step, input main_rate_est, input aux_rate_est,
                  output ready);
endinterface

interface fts_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] index;
    logic [7:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

### sv/fts_div.sv
// Radix-2 restoring divider, 16-bit dividend and divisor, one quotient bit per cycle.
module fts_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [15:0] dividend,
    input  logic [15:0] divisor,
    output logic        done,
    output logic [15:0] quotient,
    output logic [15:0] remainder
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [15:0] rem_reg, rem_next;
    logic [15:0] quo_reg, quo_next;
    logic [15:0] dsr_reg, dsr_next;
    logic [16:0] trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        trial     = {rem_reg, quo_reg[15]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = 16'(trial - {1'b0, dsr_reg});
                quo_next = {quo_reg[14:0], 1'b1};
            end
            else
            begin
                rem_next = trial[15:0];
                quo_next = {quo_reg[14:0], 1'b0};
            end
            cnt_next = cnt_reg + 4'd1;
            if (cnt_reg == 4'd15)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

### sv/fts_dp.sv
// Datapath: configuration, tick state, estimate refresh, accumulator and result register.
module fts_dp (
    input  logic              clk,
    input  logic              rst_n,
    fts_in_if.sink            in_item,
    fts_out_if.source         result,
    fts_cfg_if.sink           cfg,
    input  fts_pkg::fts_cmd_t cmd,
    output fts_pkg::fts_sts_t sts
);
    import fts_pkg::*;

    logic [7:0]  vsync_freq_reg, user_freq_reg;
    logic [7:0]  per_vsync_reg, per_user_reg;
    logic        op_reg;
    logic [15:0] jiffy_reg;
    logic [15:0] main_count_reg, user_count_reg;
    logic [7:0]  user_delta_reg, main_rate_reg, user_rate_reg;
    logic [15:0] fraction_reg, last_vsync_rate_reg, last_vsync_accum_reg;
    logic [15:0] last_main_reg, last_user_reg;
    div_sel_t    sel_reg;
    logic        out_valid_reg;
    logic [15:0] out_main_reg, out_user_reg;
    logic [7:0]  out_delta_reg, out_mfps_reg, out_ufps_reg;

    logic [15:0] dt, elapsed, dividend, divisor, prod_main, prod_user, inc;
    logic        div_done;
    logic [15:0] quo, rem;
    logic        in_fire;

    assign in_item.ready = cmd.accept_en;
    assign in_fire       = in_item.valid && cmd.accept_en;
    assign cfg.ready     = 1'b1;

    assign dt        = jiffy_reg - last_vsync_rate_reg;
    assign elapsed   = jiffy_reg - last_vsync_accum_reg;
    assign prod_main = 16'((main_count_reg - last_main_reg) * vsync_freq_reg);
    assign prod_user = 16'((user_count_reg - last_user_reg) * vsync_freq_reg);
    assign inc       = 16'(per_vsync_reg * elapsed);

    always_comb
    begin
        unique case (cmd.div_sel)
            DIV_STEPV:
            begin
                dividend = UNITS_PER_SEC;
                divisor  = {8'd0, vsync_freq_reg};
            end
            DIV_STEPU:
            begin
                dividend = UNITS_PER_SEC;
                divisor  = {8'd0, user_freq_reg};
            end
            DIV_RMAIN:
            begin
                dividend = prod_main;
                divisor  = dt;
            end
            DIV_RUSER:
            begin
                dividend = prod_user;
                divisor  = dt;
            end
            DIV_QUSER:
            begin
                dividend = fraction_reg;
                divisor  = {8'd0, per_user_reg};
            end
            default:
            begin
                dividend = fraction_reg;
                divisor  = {8'd0, per_user_reg};
            end
        endcase
    end

    fts_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (dividend),
        .divisor   (divisor),
        .done      (div_done),
        .quotient  (quo),
        .remainder (rem)
    );

    always_comb
    begin
        sts.in_fire       = in_fire;
        sts.op            = op_reg;
        sts.refresh       = (dt >= REFRESH_MIN);
        sts.per_user_zero = (per_user_reg == 8'd0);
        sts.div_done      = div_done;
        sts.out_free      = !out_valid_reg || result.ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vsync_freq_reg       <= VSYNC_FREQ_RST;
            user_freq_reg        <= USER_FREQ_RST;
            main_count_reg       <= '0;
            user_count_reg       <= '0;
            user_delta_reg       <= '0;
            main_rate_reg        <= VSYNC_FREQ_RST;
            user_rate_reg        <= VSYNC_FREQ_RST;
            fraction_reg         <= '0;
            last_vsync_rate_reg  <= '0;
            last_vsync_accum_reg <= '0;
            last_main_reg        <= '0;
            last_user_reg        <= '0;
            sel_reg              <= DIV_STEPV;
            out_valid_reg        <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                if (cfg.index == REG_VSYNC_FREQ)
                    vsync_freq_reg <= cfg.data;
                else if (cfg.index == REG_USER_FREQ)
                    user_freq_reg <= cfg.data;
            end
            if (cmd.div_start)
                sel_reg <= cmd.div_sel;
            if (cmd.clear)
            begin
                main_count_reg       <= '0;
                user_count_reg       <= '0;
                user_delta_reg       <= '0;
                fraction_reg         <= '0;
                last_vsync_rate_reg  <= '0;
                last_vsync_accum_reg <= '0;
                last_main_reg        <= '0;
                last_user_reg        <= '0;
            end
            if (div_done)
            begin
                unique case (sel_reg)
                    DIV_RMAIN:
                        main_rate_reg <= refine(main_rate_reg, quo);
                    DIV_RUSER:
                    begin
                        user_rate_reg       <= refine(user_rate_reg, quo);
                        last_main_reg       <= main_count_reg;
                        last_user_reg       <= user_count_reg;
                        last_vsync_rate_reg <= jiffy_reg;
                    end
                    DIV_QUSER:
                    begin
                        fraction_reg   <= rem;
                        user_count_reg <= user_count_reg + quo;
                        user_delta_reg <= quo[7:0];
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.accum)
            begin
                main_count_reg       <= main_count_reg + 16'd1;
                fraction_reg         <= fraction_reg + inc;
                last_vsync_accum_reg <= jiffy_reg;
            end
            if (cmd.zero_delta)
                user_delta_reg <= '0;
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg    <= in_item.op;
            jiffy_reg <= in_item.jiffy;
        end
        if (div_done && sel_reg == DIV_STEPV)
            per_vsync_reg <= (vsync_freq_reg == 8'd0) ? 8'd0 : quo[7:0];
        if (div_done && sel_reg == DIV_STEPU)
            per_user_reg <= (user_freq_reg == 8'd0) ? 8'd0 : quo[7:0];
        if (cmd.emit)
        begin
            out_main_reg  <= main_count_reg;
            out_user_reg  <= user_count_reg;
            out_delta_reg <= user_delta_reg;
            out_mfps_reg  <= main_rate_reg;
            out_ufps_reg  <= user_rate_reg;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.main_tick     = out_main_reg;
    assign result.aux_tick      = out_user_reg;
    assign result.aux_tick_step = out_delta_reg;
    assign result.main_rate_est = out_mfps_reg;
    assign result.aux_rate_est  = out_ufps_reg;

endmodule

### sv/fts_ctrl.sv
// Controller state machine sequencing divisions, accumulation and result hand-off.
module fts_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  fts_pkg::fts_sts_t sts,
    output fts_pkg::fts_cmd_t cmd
);
    import fts_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd.accept_en  = 1'b0;
        cmd.clear      = 1'b0;
        cmd.div_start  = 1'b0;
        cmd.div_sel    = DIV_QUSER;
        cmd.accum      = 1'b0;
        cmd.zero_delta = 1'b0;
        cmd.emit       = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.accept_en = 1'b1;
                if (sts.in_fire)
                    state_next = S_CLEAR;
            end
            S_CLEAR:
            begin
                if (sts.op == OP_RESET)
                begin
                    cmd.clear  = 1'b1;
                    state_next = S_DONE;
                end
                else
                    state_next = S_STEPV;
            end
            S_STEPV:
            begin
                cmd.div_sel   = DIV_STEPV;
                cmd.div_start = 1'b1;
                state_next    = S_STEPV_W;
            end
            S_STEPV_W:
                if (sts.div_done)
                    state_next = S_STEPU;
            S_STEPU:
            begin
                cmd.div_sel   = DIV_STEPU;
                cmd.div_start = 1'b1;
                state_next    = S_STEPU_W;
            end
            S_STEPU_W:
                if (sts.div_done)
                    state_next = sts.refresh ? S_RMAIN : S_ACCUM;
            S_RMAIN:
            begin
                cmd.div_sel   = DIV_RMAIN;
                cmd.div_start = 1'b1;
                state_next    = S_RMAIN_W;
            end
            S_RMAIN_W:
                if (sts.div_done)
                    state_next = S_RUSER;
            S_RUSER:
            begin
                cmd.div_sel   = DIV_RUSER;
                cmd.div_start = 1'b1;
                state_next    = S_RUSER_W;
            end
            S_RUSER_W:
                if (sts.div_done)
                    state_next = S_ACCUM;
            S_ACCUM:
            begin
                cmd.accum  = 1'b1;
                state_next = S_QUSER;
            end
            S_QUSER:
            begin
                if (sts.per_user_zero)
                begin
                    cmd.zero_delta = 1'b1;
                    state_next     = S_DONE;
                end
                else
                begin
                    cmd.div_sel   = DIV_QUSER;
                    cmd.div_start = 1'b1;
                    state_next    = S_QUSER_W;
                end
            end
            S_QUSER_W:
                if (sts.div_done)
                    state_next = S_DONE;
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

endmodule

### sv/frame_tick_rate_converter.sv
// Top level of the frame tick rate converter: controller plus datapath.
// One item at a time. A reset command is decoded, clears the tick state and is handed off.
// A frame update runs three divisions on the shared radix-2 divider (two step sizes and
// the accumulator split); when the jiffy count has advanced by at least 31 since the last
// refresh, two more divisions refresh the fps estimates. A zero user step skips the split.
// Beside the divider, the steps are decode, accumulation and hand-off. The input is ready
// again in the same cycle as the result is posted. A finished result waits in the output
// register, and the next item is taken while it waits; that item's own result holds until
// the waiting one is taken.
module frame_tick_rate_converter (
    input  logic      clk,
    input  logic      rst_n,
    fts_in_if.sink    in_item,
    fts_out_if.source result,
    fts_cfg_if.sink   cfg
);
    import fts_pkg::*;

    fts_cmd_t cmd;
    fts_sts_t sts;

    fts_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    fts_dp u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_item (in_item),
        .result  (result),
        .cfg     (cfg),
        .cmd     (cmd),
        .sts     (sts)
    );

endmodule

### sv/fts_chk.sv
// Port-level checker for the frame tick rate converter and its bind.
module fts_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] main_tick,
    input logic [7:0]  main_rate_est
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(main_tick) && $stable(main_rate_est))
        else $error("result changed while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while an item is in work");

    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
        else $error("result posted in the cycle after the transfer");

    a_ready_after_post: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> in_ready)
        else $error("not ready after posting a result");

endmodule

bind frame_tick_rate_converter fts_chk u_fts_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_item.valid),
    .in_ready      (in_item.ready),
    .out_valid     (result.valid),
    .out_ready     (result.ready),
    .main_tick     (result.main_tick),
    .main_rate_est (result.main_rate_est)
);
